// ===== hw/rtl/rcs_pkg.sv =====
// Shared types, constants and codes for the RC servo / PPM / SBUS output sequencer.
package rcs_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int FRAME_BYTES  = 25;

  localparam int CH_IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int FRAME_IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam int PPM_LAST_I   = 2 * NUM_CHANNELS + 1;
  localparam int SERVO_LAST_I = 2 * NUM_CHANNELS - 1;
  localparam int STEP_MAX     = (FRAME_BYTES > PPM_LAST_I) ? FRAME_BYTES : PPM_LAST_I;
  localparam int STEP_W       = $clog2(STEP_MAX + 1);

  typedef logic [CH_IDX_W-1:0]    ch_idx_t;
  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
  typedef logic [STEP_W-1:0]      step_t;
  typedef logic [STEP_W:0]        step_ext_t;

  localparam step_ext_t STEP_FB    = step_ext_t'(FRAME_BYTES);
  localparam step_ext_t PPM_LAST   = step_ext_t'(PPM_LAST_I);
  localparam step_ext_t SERVO_LAST = step_ext_t'(SERVO_LAST_I);
  localparam step_ext_t NUM_CH_EXT = step_ext_t'(NUM_CHANNELS);

  // Timer reload values, all mod 2^16
  localparam logic [15:0] SERVO_BASE  = 16'(32'h10000 - 813);
  localparam logic [15:0] SERVO_FRAME = 16'(32'h20000 - 2500);
  localparam logic [15:0] PPM_BASE    = 16'(32'h10000 - 600);
  localparam logic [15:0] PPM_MARK    = 16'(32'h10000 - 400);
  localparam logic [15:0] PPM_TAIL    = 16'(32'h10000 - 10000);
  localparam logic [15:0] SBUS_BYTE   = 16'(32'h10000 - 120);
  localparam logic [15:0] SBUS_GAP    = 16'(32'h10000 - 11000);

  localparam logic [7:0] PWM_HONORED = 8'h63;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_EXPIRY   = 2'd0,
    CMD_WR_CHAN  = 2'd1,
    CMD_WR_FRAME = 2'd2,
    CMD_MODE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_SERVO = 2'd0,
    MODE_PPM   = 2'd1,
    MODE_SBUS  = 2'd2
  } mode_t;

  // mode request code with no mode of its own; it asks for servo
  localparam logic [1:0] REQ_SERVO_ALIAS = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_MASK    = 3'd0,
    CFG_SWITCH_MASK = 3'd1,
    CFG_SCALE_MUL   = 3'd2,
    CFG_SCALE_SHIFT = 3'd3,
    CFG_SWITCH_THR  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  idx;
    logic [9:0]  value;
    mode_t       mode;
  } item_t;

  typedef struct packed {
    logic [15:0] timer_reload;
    logic        sbus_pin;
    logic        ppm_pin;
    logic [7:0]  channel_pins;
    logic        uart_valid;
    logic [7:0]  uart_byte;
    logic        uart_parity;
    logic        pwm_valid;
    logic [2:0]  pwm_channel;
    logic [7:0]  pwm_duty;
  } res_t;

endpackage

// ===== hw/rtl/rcs_front.sv =====
// Front end: accepts input beats, drops out-of-range writes, queues commands for the back end.
module rcs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     cmd,
  input  logic [4:0]     index,
  input  logic [9:0]     value,
  input  logic [1:0]     requested_mode,
  output logic           q_valid,
  output rcs_pkg::item_t q_item,
  input  logic           q_pop
);

  rcs_pkg::item_t                  mem [rcs_pkg::CMDQ_DEPTH];
  logic [rcs_pkg::CMDQ_PTR_W-1:0]  wr_ptr;
  logic [rcs_pkg::CMDQ_PTR_W-1:0]  rd_ptr;
  logic [rcs_pkg::CMDQ_CNT_W-1:0]  count;
  logic                            keep;
  logic                            enq;
  rcs_pkg::item_t                  item_in;

  // classify
  always_comb begin
    item_in.cmd   = rcs_pkg::cmd_t'(cmd);
    item_in.idx   = index;
    item_in.value = value;
    item_in.mode  = (requested_mode == rcs_pkg::REQ_SERVO_ALIAS) ? rcs_pkg::MODE_SERVO
                                                                 : rcs_pkg::mode_t'(requested_mode);
    case (rcs_pkg::cmd_t'(cmd))
      rcs_pkg::CMD_WR_CHAN:  keep = ({1'b0, index} < 6'(rcs_pkg::NUM_CHANNELS));
      rcs_pkg::CMD_WR_FRAME: keep = ({1'b0, index} < 6'(rcs_pkg::FRAME_BYTES));
      default:               keep = 1'b1;
    endcase
  end

  assign full    = (count == rcs_pkg::CMDQ_CNT_W'(rcs_pkg::CMDQ_DEPTH));
  assign enq     = push && !full && keep;
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rcs_back.sv =====
// Back end: holds sequencer state and config, executes one queued command per cycle while the result queue is not full.
module rcs_back (
  input  logic             clk,
  input  logic             rst,
  input  rcs_pkg::cfg_wr_t cfg_wr,
  input  logic             q_valid,
  input  rcs_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic             res_full,
  output logic             res_push,
  output rcs_pkg::res_t    res_item
);

  // config
  logic [7:0]  pwm_enable_mask;
  logic [7:0]  switch_enable_mask;
  logic [15:0] servo_scale_mul;
  logic [4:0]  servo_scale_shift;
  logic [9:0]  switch_threshold;

  // sequencer state
  rcs_pkg::step_t step, step_next;
  rcs_pkg::mode_t mode, mode_next;
  rcs_pkg::mode_t pend, pend_next;
  logic           change_pending, change_pending_next;
  logic [7:0]     pins, pins_next;
  logic [15:0]    staged, staged_next;
  logic [15:0]    pulse, pulse_next;
  logic [15:0]    reload, reload_next;
  logic           sbus_lvl, sbus_lvl_next;
  logic           ppm_lvl, ppm_lvl_next;

  logic [9:0]     chan  [rcs_pkg::NUM_CHANNELS];
  logic [7:0]     frame [rcs_pkg::FRAME_BYTES];

  logic                  fire;
  logic                  jump;
  rcs_pkg::ch_idx_t      k;
  rcs_pkg::ch_idx_t      prev;
  logic [9:0]            chan_val;
  logic [7:0]            frame_byte;
  logic [25:0]           prod;
  logic [25:0]           scaled;
  rcs_pkg::step_ext_t    s_ext;
  rcs_pkg::step_ext_t    s_inc;
  rcs_pkg::step_ext_t    half;
  logic [7:0]            pwm_en;
  logic [7:0]            held_mask;

  assign fire     = q_valid && !res_full;
  assign q_pop    = fire;
  assign res_push = fire && (q_item.cmd == rcs_pkg::CMD_EXPIRY);

  assign s_ext      = {1'b0, step};
  assign s_inc      = s_ext + 1'b1;
  assign half       = s_ext >> 1;
  assign k          = rcs_pkg::ch_idx_t'(half);
  assign prev       = (k == '0) ? rcs_pkg::ch_idx_t'(rcs_pkg::NUM_CHANNELS - 1) : k - 1'b1;
  assign chan_val   = chan[k];
  assign frame_byte = frame[rcs_pkg::frame_idx_t'(step)];
  assign prod       = 26'(chan_val) * 26'(servo_scale_mul);
  assign scaled     = prod >> servo_scale_shift;
  assign pwm_en     = pwm_enable_mask & rcs_pkg::PWM_HONORED;
  assign held_mask  = pwm_en | switch_enable_mask;

  always_comb begin
    step_next           = step;
    mode_next           = mode;
    pend_next           = pend;
    change_pending_next = change_pending;
    pins_next           = pins;
    staged_next         = staged;
    pulse_next          = pulse;
    reload_next         = reload;
    sbus_lvl_next       = sbus_lvl;
    ppm_lvl_next        = ppm_lvl;
    jump                = 1'b0;
    res_item            = '0;

    if (fire) begin
      case (q_item.cmd)
        rcs_pkg::CMD_MODE: begin
          pend_next           = q_item.mode;
          change_pending_next = 1'b1;
        end
        rcs_pkg::CMD_EXPIRY: begin
          case (mode)
            rcs_pkg::MODE_SBUS: begin
              sbus_lvl_next = 1'b1;
              if (s_ext >= rcs_pkg::STEP_FB) begin
                step_next = '0;
              end else begin
                res_item.uart_valid  = 1'b1;
                res_item.uart_byte   = frame_byte;
                res_item.uart_parity = ^frame_byte;
                step_next            = rcs_pkg::step_t'(s_inc);
              end
              reload_next = ({1'b0, step_next} >= rcs_pkg::STEP_FB) ? rcs_pkg::SBUS_GAP
                                                                    : rcs_pkg::SBUS_BYTE;
              if (change_pending && step_next == '0) begin
                change_pending_next = 1'b0;
                if (pend == rcs_pkg::MODE_PPM) begin
                  mode_next = rcs_pkg::MODE_PPM;
                end else if (pend == rcs_pkg::MODE_SERVO) begin
                  mode_next = rcs_pkg::MODE_SERVO;
                end
              end
            end
            rcs_pkg::MODE_PPM: begin
              if (s_ext == rcs_pkg::PPM_LAST) begin
                ppm_lvl_next = 1'b0;
                reload_next  = rcs_pkg::PPM_TAIL;
              end else if (s_ext < rcs_pkg::PPM_LAST && !step[0]) begin
                ppm_lvl_next = 1'b1;
                reload_next  = rcs_pkg::PPM_MARK;
                if (half < rcs_pkg::NUM_CH_EXT) begin
                  staged_next = rcs_pkg::PPM_BASE - 16'(chan_val);
                end
              end else if (s_ext < rcs_pkg::PPM_LAST) begin
                ppm_lvl_next = 1'b0;
                reload_next  = staged;
              end
              if (change_pending && step == '0) begin
                change_pending_next = 1'b0;
                if (pend == rcs_pkg::MODE_SBUS) begin
                  mode_next = rcs_pkg::MODE_SBUS;
                  jump      = 1'b1;
                end else if (pend == rcs_pkg::MODE_SERVO) begin
                  mode_next = rcs_pkg::MODE_SERVO;
                end
              end
              if (jump) begin
                step_next = '0;
              end else begin
                step_next = (s_inc > rcs_pkg::PPM_LAST) ? '0 : rcs_pkg::step_t'(s_inc);
              end
            end
            default: begin
              if (s_ext <= rcs_pkg::SERVO_LAST) begin
                if (!step[0]) begin
                  if (!held_mask[prev]) begin
                    pins_next[prev] = 1'b0;
                  end
                  pulse_next  = rcs_pkg::SERVO_BASE - scaled[15:0];
                  reload_next = pulse_next;
                end else begin
                  reload_next = rcs_pkg::SERVO_FRAME - pulse;
                  if (pwm_en[k]) begin
                    res_item.pwm_valid   = 1'b1;
                    res_item.pwm_channel = 3'(k);
                    res_item.pwm_duty    = chan_val[9:2];
                  end else if (switch_enable_mask[k]) begin
                    pins_next[k] = (chan_val >= switch_threshold);
                  end else begin
                    pins_next[k] = 1'b1;
                  end
                end
              end
              if (change_pending && step == '0) begin
                change_pending_next = 1'b0;
                if (pend == rcs_pkg::MODE_SBUS) begin
                  mode_next = rcs_pkg::MODE_SBUS;
                  jump      = 1'b1;
                end else if (pend == rcs_pkg::MODE_PPM) begin
                  mode_next = rcs_pkg::MODE_PPM;
                end
              end
              if (jump) begin
                step_next = '0;
              end else begin
                step_next = (s_inc > rcs_pkg::SERVO_LAST) ? '0 : rcs_pkg::step_t'(s_inc);
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    res_item.timer_reload = reload_next;
    res_item.sbus_pin     = sbus_lvl_next;
    res_item.ppm_pin      = ppm_lvl_next;
    res_item.channel_pins = pins_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_enable_mask    <= '0;
      switch_enable_mask <= '0;
      servo_scale_mul    <= 16'd1;
      servo_scale_shift  <= '0;
      switch_threshold   <= 10'd500;
    end else if (cfg_wr.we) begin
      case (rcs_pkg::cfg_idx_t'(cfg_wr.index))
        rcs_pkg::CFG_PWM_MASK:    pwm_enable_mask    <= cfg_wr.data[7:0];
        rcs_pkg::CFG_SWITCH_MASK: switch_enable_mask <= cfg_wr.data[7:0];
        rcs_pkg::CFG_SCALE_MUL:   servo_scale_mul    <= cfg_wr.data;
        rcs_pkg::CFG_SCALE_SHIFT: servo_scale_shift  <= cfg_wr.data[4:0];
        rcs_pkg::CFG_SWITCH_THR:  switch_threshold   <= cfg_wr.data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= '0;
      mode           <= rcs_pkg::MODE_SERVO;
      pend           <= rcs_pkg::MODE_SERVO;
      change_pending <= 1'b0;
      pins           <= '0;
      staged         <= '0;
      pulse          <= '0;
      reload         <= '0;
      sbus_lvl       <= 1'b0;
      ppm_lvl        <= 1'b0;
      for (int i = 0; i < rcs_pkg::NUM_CHANNELS; i++) begin
        chan[i] <= '0;
      end
      for (int i = 0; i < rcs_pkg::FRAME_BYTES; i++) begin
        frame[i] <= '0;
      end
    end else begin
      step           <= step_next;
      mode           <= mode_next;
      pend           <= pend_next;
      change_pending <= change_pending_next;
      pins           <= pins_next;
      staged         <= staged_next;
      pulse          <= pulse_next;
      reload         <= reload_next;
      sbus_lvl       <= sbus_lvl_next;
      ppm_lvl        <= ppm_lvl_next;
      if (fire && q_item.cmd == rcs_pkg::CMD_WR_CHAN) begin
        chan[rcs_pkg::ch_idx_t'(q_item.idx)] <= q_item.value;
      end
      if (fire && q_item.cmd == rcs_pkg::CMD_WR_FRAME) begin
        frame[rcs_pkg::frame_idx_t'(q_item.idx)] <= q_item.value[7:0];
      end
    end
  end

endmodule

// ===== hw/rtl/rcs_outq.sv =====
// Result queue: two registered entries between the back end and the result ports.
module rcs_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_push,
  input  rcs_pkg::res_t res_in,
  output logic          res_full,
  input  logic          pop,
  output logic          empty,
  output rcs_pkg::res_t res_out
);

  rcs_pkg::res_t                   mem [rcs_pkg::OUTQ_DEPTH];
  logic [rcs_pkg::OUTQ_PTR_W-1:0]  wr_ptr;
  logic [rcs_pkg::OUTQ_PTR_W-1:0]  rd_ptr;
  logic [rcs_pkg::OUTQ_CNT_W-1:0]  count;
  logic                            deq;

  assign res_full = (count == rcs_pkg::OUTQ_CNT_W'(rcs_pkg::OUTQ_DEPTH));
  assign empty    = (count == '0);
  assign deq      = pop && !empty;
  assign res_out  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      mem[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({res_push, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rc_servo_ppm_sbus_output_sequencer.sv =====
// Top level of the RC servo / PPM / SBUS output sequencer.
//
// Input side is a queue: drive cmd/index/value/requested_mode with push; a beat
// is taken on a clock edge with push high and full low. Commands: timer expiry,
// channel value write, frame byte write, mode request.
// Result side is a queue: while empty is low the oldest result sits on the
// result ports; pop with empty low takes it. Only timer expiries make results.
// Config: cfg_valid/cfg_index/cfg_data, cfg_ready is always high; write only
// while the block is idle.
// Beats are registered in the command queue, results in the result queue.
// One beat per cycle sustained while the result queue is not full; each command
// runs in one path (channel read, scale multiply, shift and reload subtract).
// A 4-deep command queue feeds the back end; a 2-deep result queue feeds the
// outputs. When the receiver stalls, the result queue fills, the back end
// holds, then the command queue fills and full rises.
// Reset (rst, synchronous): queues empty, servo mode, step 0, all channel
// values, frame bytes, pins and reloads zero, config to its defaults.
module rc_servo_ppm_sbus_output_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      cmd,
  input  logic [4:0]                      index,
  input  logic [9:0]                      value,
  input  logic [1:0]                      requested_mode,
  output logic                            empty,
  input  logic                            pop,
  output logic [15:0]                     timer_reload,
  output logic                            sbus_pin,
  output logic                            ppm_pin,
  output logic [7:0]                      channel_pins,
  output logic                            uart_valid,
  output logic [7:0]                      uart_byte,
  output logic                            uart_parity,
  output logic                            pwm_valid,
  output logic [2:0]                      pwm_channel,
  output logic [7:0]                      pwm_duty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic             q_valid;
  logic             q_pop;
  rcs_pkg::item_t   q_item;
  logic             res_push;
  logic             res_full;
  rcs_pkg::res_t    res_item;
  rcs_pkg::res_t    res_out;
  rcs_pkg::cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  rcs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .cmd            (cmd),
    .index          (index),
    .value          (value),
    .requested_mode (requested_mode),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  rcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  rcs_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_item),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_out)
  );

  assign timer_reload = res_out.timer_reload;
  assign sbus_pin     = res_out.sbus_pin;
  assign ppm_pin      = res_out.ppm_pin;
  assign channel_pins = res_out.channel_pins;
  assign uart_valid   = res_out.uart_valid;
  assign uart_byte    = res_out.uart_byte;
  assign uart_parity  = res_out.uart_parity;
  assign pwm_valid    = res_out.pwm_valid;
  assign pwm_channel  = res_out.pwm_channel;
  assign pwm_duty     = res_out.pwm_duty;

  // back end never pulls from an empty command queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("command queue popped while empty");

  // a result beat comes only from an executed timer expiry
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (q_pop && q_item.cmd == rcs_pkg::CMD_EXPIRY))
    else $error("result pushed without an expiry command");

  // result queue never overflows
  a_no_ovf: assert property (@(posedge clk) disable iff (rst) !(res_push && res_full))
    else $error("result queue overflow");

  // reset leaves no stale results visible
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

endmodule
